// ===== hdl/triangle_unit_normal_defines.svh =====
// Assertion helpers for the triangle normal RTL.
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define TUN_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define TUN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tun_pkg.sv =====
package tun_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = 25;
    localparam int PROD_W  = 50;
    localparam int CROSS_W = 51;
    localparam int MAG_W   = 50;   // |n| <= 2^49
    localparam int HALF_W  = 25;   // split of MAG_W for squaring
    localparam int SQ_W    = 100;
    localparam int SUM_W   = 102;
    localparam int RES_W   = 134;  // residual of the root search, signed
    localparam int K_W     = 15;   // result magnitude 0..16384
    localparam int NORM_W  = 16;
    localparam int NSQ_SHIFT = 30; // 2^30 = (2 * 2^14)^2
    localparam logic [K_W-1:0] K_ONE = 15'd16384;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } tun_in_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic                     degenerate;
    } tun_out_t;

    // side data riding alongside the root search
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } tun_side_t;

endpackage

// ===== hdl/tun_norm_lane.sv =====
// Bit-serial exact root search, one result bit per stage:
// largest k with (2k-1)^2 * sum <= sq * 2^30.
// Keeps r = sq*2^30 - m^2*sum and p = m*sum, m = 2k-1.
module tun_norm_lane
    import tun_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [SUM_W-1:0] sum,
    input  logic [SQ_W-1:0]  sq,
    output logic [K_W-1:0]   k
);

    logic signed [RES_W-1:0] r_reg [K_W];
    logic signed [RES_W-1:0] p_reg [K_W];
    logic signed [RES_W-1:0] s_reg [K_W];
    logic        [K_W-1:0]   k_reg [K_W];

    logic signed [RES_W-1:0] s0;
    logic signed [RES_W-1:0] r0;
    logic signed [RES_W-1:0] p0;

    // start at m = -1
    assign s0 = signed'(RES_W'(sum));
    assign r0 = signed'(RES_W'(sq) << NSQ_SHIFT) - s0;
    assign p0 = -s0;

    for (genvar i = 0; i < K_W; i++) begin : g_stage
        localparam int J = K_W - 1 - i;
        logic signed [RES_W-1:0] r_prev;
        logic signed [RES_W-1:0] p_prev;
        logic signed [RES_W-1:0] s_prev;
        logic        [K_W-1:0]   k_prev;
        logic signed [RES_W-1:0] r_try;

        if (i == 0) begin : g_first
            assign r_prev = r0;
            assign p_prev = p0;
            assign s_prev = s0;
            assign k_prev = '0;
        end else begin : g_next
            assign r_prev = r_reg[i-1];
            assign p_prev = p_reg[i-1];
            assign s_prev = s_reg[i-1];
            assign k_prev = k_reg[i-1];
        end

        // m grows by d = 2^(J+1): m^2 s grows by 2dp + d^2 s
        assign r_try = r_prev - (p_prev <<< (J + 2)) - (s_prev <<< (2 * J + 2));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[i] <= s_prev;
                if (!r_try[RES_W-1])
                begin
                    r_reg[i] <= r_try;
                    p_reg[i] <= p_prev + (s_prev <<< (J + 1));
                    k_reg[i] <= k_prev | (K_W'(1) << J);
                end
                else
                begin
                    r_reg[i] <= r_prev;
                    p_reg[i] <= p_prev;
                    k_reg[i] <= k_prev;
                end
            end
        end
    end

    assign k = k_reg[K_W-1];

endmodule

// ===== hdl/triangle_unit_normal.sv =====
// Channel  Payload    Handshake                 Direction
// vert     tun_in_t   vert_valid / vert_ready   in:  vertices a, b, c
// norm     tun_out_t  norm_valid / norm_ready   out: unit normal, degenerate
//
// One triangle per cycle sustained while norm is not stalled.
// Six front stages (edges, products, cross, split squares, squares, sum), then
// a 15-stage root search, one result bit per stage, then the output register.
// Reset clears only the valid bits; the data registers are not reset.
// A stall on norm freezes the whole pipeline; nothing is dropped or repeated.
module triangle_unit_normal
    import tun_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     vert_valid,
    output logic     vert_ready,
    input  tun_in_t  vert,
    output logic     norm_valid,
    input  logic     norm_ready,
    output tun_out_t norm
);

`include "triangle_unit_normal_defines.svh"

    localparam int NSTG = 6 + K_W + 1;

    logic            en;
    logic [NSTG-1:0] vld_reg;

    // stage 1
    logic signed [DIFF_W-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    // stage 2
    logic signed [PROD_W-1:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;
    // stage 3
    logic signed [CROSS_W-1:0] n_next [3];
    logic [MAG_W-1:0] mag_reg [3];
    logic [2:0]       neg3_reg;
    // stage 4
    logic [2*HALF_W-1:0] hh_reg [3];
    logic [2*HALF_W-1:0] hl_reg [3];
    logic [2*HALF_W-1:0] ll_reg [3];
    logic [2:0]          neg4_reg;
    // stage 5
    logic [SQ_W-1:0] sq5_reg [3];
    logic [2:0]      neg5_reg;
    // stage 6
    logic [SQ_W-1:0]  sq6_reg [3];
    logic [SUM_W-1:0] sum_reg;
    logic [2:0]       neg6_reg;
    // root search
    tun_side_t      side_reg [K_W];
    logic [K_W-1:0] k_res [3];
    tun_out_t       norm_reg;

    assign en         = !vld_reg[NSTG-1] || norm_ready;
    assign vert_ready = en;
    assign norm_valid = vld_reg[NSTG-1];
    assign norm       = norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], vert_valid};
    end

    assign n_next[0] = CROSS_W'(p_yz_reg) - CROSS_W'(p_zy_reg);
    assign n_next[1] = CROSS_W'(p_zx_reg) - CROSS_W'(p_xz_reg);
    assign n_next[2] = CROSS_W'(p_xy_reg) - CROSS_W'(p_yx_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg <= DIFF_W'(vert.a_x) - DIFF_W'(vert.b_x);
            uy_reg <= DIFF_W'(vert.a_y) - DIFF_W'(vert.b_y);
            uz_reg <= DIFF_W'(vert.a_z) - DIFF_W'(vert.b_z);
            vx_reg <= DIFF_W'(vert.b_x) - DIFF_W'(vert.c_x);
            vy_reg <= DIFF_W'(vert.b_y) - DIFF_W'(vert.c_y);
            vz_reg <= DIFF_W'(vert.b_z) - DIFF_W'(vert.c_z);

            p_yz_reg <= uy_reg * vz_reg;
            p_zy_reg <= uz_reg * vy_reg;
            p_zx_reg <= uz_reg * vx_reg;
            p_xz_reg <= ux_reg * vz_reg;
            p_xy_reg <= ux_reg * vy_reg;
            p_yx_reg <= uy_reg * vx_reg;

            for (int i = 0; i < 3; i++)
            begin
                neg3_reg[i] <= n_next[i][CROSS_W-1];
                mag_reg[i]  <= n_next[i][CROSS_W-1] ? MAG_W'(-n_next[i])
                                                    : MAG_W'(n_next[i]);

                hh_reg[i] <= mag_reg[i][MAG_W-1:HALF_W] * mag_reg[i][MAG_W-1:HALF_W];
                hl_reg[i] <= mag_reg[i][MAG_W-1:HALF_W] * mag_reg[i][HALF_W-1:0];
                ll_reg[i] <= mag_reg[i][HALF_W-1:0] * mag_reg[i][HALF_W-1:0];

                sq5_reg[i] <= (SQ_W'(hh_reg[i]) << (2 * HALF_W))
                            + (SQ_W'(hl_reg[i]) << (HALF_W + 1))
                            + SQ_W'(ll_reg[i]);

                sq6_reg[i] <= sq5_reg[i];
            end
            neg4_reg <= neg3_reg;
            neg5_reg <= neg4_reg;
            neg6_reg <= neg5_reg;
            sum_reg  <= SUM_W'(sq5_reg[0]) + SUM_W'(sq5_reg[1]) + SUM_W'(sq5_reg[2]);

            side_reg[0] <= '{neg: neg6_reg, degen: (sum_reg == '0)};
            for (int i = 1; i < K_W; i++)
                side_reg[i] <= side_reg[i-1];

            if (side_reg[K_W-1].degen)
            begin
                norm_reg.normal_x   <= '0;
                norm_reg.normal_y   <= '0;
                norm_reg.normal_z   <= '0;
                norm_reg.degenerate <= 1'b1;
            end
            else
            begin
                norm_reg.normal_x   <= side_reg[K_W-1].neg[0] ? -NORM_W'(k_res[0])
                                                              : NORM_W'(k_res[0]);
                norm_reg.normal_y   <= side_reg[K_W-1].neg[1] ? -NORM_W'(k_res[1])
                                                              : NORM_W'(k_res[1]);
                norm_reg.normal_z   <= side_reg[K_W-1].neg[2] ? -NORM_W'(k_res[2])
                                                              : NORM_W'(k_res[2]);
                norm_reg.degenerate <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        tun_norm_lane u_lane (
            .clk (clk),
            .en  (en),
            .sum (sum_reg),
            .sq  (sq6_reg[g]),
            .k   (k_res[g])
        );
    end

    `TUN_ASSERT_IMPL(a_degen_zero, norm_valid && norm.degenerate,
        norm.normal_x == 0 && norm.normal_y == 0 && norm.normal_z == 0,
        "degenerate result with nonzero normal")
    `TUN_ASSERT_IMPL(a_k_range, vld_reg[NSTG-2] && !side_reg[K_W-1].degen,
        k_res[0] <= K_ONE && k_res[1] <= K_ONE && k_res[2] <= K_ONE,
        "root search result above one")
    `TUN_ASSERT_NEXT(a_stall_hold, norm_valid && !norm_ready,
        norm_valid && $stable(norm) && $stable(vld_reg),
        "pipeline moved during stall")
    `TUN_ASSERT_IMPL(a_ready, 1'b1, vert_ready == (!norm_valid || norm_ready),
        "input ready does not follow output stall")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import tun_pkg::*;

    localparam int N_RANDOM       = 1830;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic     clk;
    logic     rst_n;
    logic     vert_valid;
    logic     vert_ready;
    tun_in_t  vert;
    logic     norm_valid;
    logic     norm_ready;
    tun_out_t norm;

    tun_in_t  pending_tris[$];
    tun_out_t expected_normals[$];
    int       err_count;
    int       tri_count;
    int       degen_count;
    int       in_gap;
    int       out_stall;
    int       idle_cycles;
    bit       no_gap_burst;

    triangle_unit_normal i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vert_valid(vert_valid),
        .vert_ready(vert_ready),
        .vert      (vert),
        .norm_valid(norm_valid),
        .norm_ready(norm_ready),
        .norm      (norm)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Rounded magnitude: largest k with (2k-1)^2 * sumsq <= comp^2 * 2^30
    function automatic tun_out_t predict_normal(tun_in_t t);
        longint      ux, uy, uz, vx, vy, vz;
        longint      n [3];
        logic [199:0] mg, sumsq, rhs, lhs, m2;
        int          lo, hi, mid;
        logic [15:0] r [3];
        tun_out_t    res;
        ux = longint'(t.a_x) - longint'(t.b_x);
        uy = longint'(t.a_y) - longint'(t.b_y);
        uz = longint'(t.a_z) - longint'(t.b_z);
        vx = longint'(t.b_x) - longint'(t.c_x);
        vy = longint'(t.b_y) - longint'(t.c_y);
        vz = longint'(t.b_z) - longint'(t.c_z);
        n[0] = uy * vz - uz * vy;
        n[1] = uz * vx - ux * vz;
        n[2] = ux * vy - uy * vx;
        sumsq = '0;
        for (int i = 0; i < 3; i++)
        begin
            mg = n[i] < 0 ? 200'(-n[i]) : 200'(n[i]);
            sumsq = sumsq + mg * mg;
        end
        res = '0;
        if (sumsq == 0)
        begin
            res.degenerate = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++)
        begin
            mg = n[i] < 0 ? 200'(-n[i]) : 200'(n[i]);
            rhs = (mg * mg) << NSQ_SHIFT;
            lo = 0;
            hi = 16384;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                m2 = 200'(2 * mid - 1);
                lhs = sumsq * (m2 * m2);
                if (lhs <= rhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            r[i] = n[i] < 0 ? -16'(lo) : 16'(lo);
        end
        res.normal_x = r[0];
        res.normal_y = r[1];
        res.normal_z = r[2];
        return res;
    endfunction

    task automatic report_mismatch(string what);
        err_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic tun_in_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz);
        tun_in_t t;
        t.a_x = COORD_W'(ax); t.a_y = COORD_W'(ay); t.a_z = COORD_W'(az);
        t.b_x = COORD_W'(bx); t.b_y = COORD_W'(by); t.b_z = COORD_W'(bz);
        t.c_x = COORD_W'(cx); t.c_y = COORD_W'(cy); t.c_z = COORD_W'(cz);
        return t;
    endfunction

    function automatic int rand_coord(int mode);
        case (mode)
            0: return int'($urandom_range(0, 32'hFF_FFFF)) - 8388608;
            1: return int'($urandom_range(0, 8191)) - 4096;
            2: return int'($urandom_range(0, 15)) - 8;
            default: return $urandom_range(0, 1) ? 8388607 - int'($urandom_range(0, 3))
                                                 : -8388608 + int'($urandom_range(0, 3));
        endcase
    endfunction

    // Driver: one transfer per valid, random gap drawn per item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_valid <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (vert_valid && vert_ready)
            begin
                expected_normals.push_back(predict_normal(vert));
                tri_count++;
            end
            if (!vert_valid || vert_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    vert_valid <= 1'b0;
                end
                else if (pending_tris.size() > 0)
                begin
                    vert <= pending_tris.pop_front();
                    vert_valid <= 1'b1;
                    in_gap <= no_gap_burst ? 0 : $urandom_range(0, 10);
                end
                else
                    vert_valid <= 1'b0;
            end
        end
    end

    // Monitor: random receiver stalls, field-by-field compare
    always @(posedge clk or negedge rst_n)
    begin
        tun_out_t exp_n;
        if (!rst_n)
        begin
            norm_ready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            if (norm_valid && norm_ready)
            begin
                if (expected_normals.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    exp_n = expected_normals.pop_front();
                    if (exp_n.degenerate)
                        degen_count++;
                    if (norm.normal_x !== exp_n.normal_x)
                        report_mismatch($sformatf("normal_x %0d, expected %0d",
                                                  norm.normal_x, exp_n.normal_x));
                    if (norm.normal_y !== exp_n.normal_y)
                        report_mismatch($sformatf("normal_y %0d, expected %0d",
                                                  norm.normal_y, exp_n.normal_y));
                    if (norm.normal_z !== exp_n.normal_z)
                        report_mismatch($sformatf("normal_z %0d, expected %0d",
                                                  norm.normal_z, exp_n.normal_z));
                    if (norm.degenerate !== exp_n.degenerate)
                        report_mismatch($sformatf("degenerate %0b, expected %0b",
                                                  norm.degenerate, exp_n.degenerate));
                end
            end
            if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                norm_ready <= 1'b0;
            end
            else
            begin
                norm_ready <= 1'b1;
                if (norm_valid && norm_ready)
                    out_stall <= no_gap_burst ? 0 : $urandom_range(0, 10);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((vert_valid && vert_ready) || (norm_valid && norm_ready)))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int ax, ay, az, dx, dy, dz, k, mode;
        rst_n = 1'b0;
        vert = '0;
        err_count = 0;
        tri_count = 0;
        degen_count = 0;
        no_gap_burst = 1'b0;

        // directed: degenerate, axis-aligned (+z, -x, +x, +y), extremes
        pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_tris.push_back(make_tri(5, -7, 9, 5, -7, 9, 5, -7, 9));
        pending_tris.push_back(make_tri(3, 3, 3, 1, 1, 1, -1, -1, -1));
        pending_tris.push_back(make_tri(1, 0, 0, 0, 0, 0, 0, -1, 0));
        pending_tris.push_back(make_tri(0, 1, 0, 0, 0, 0, 1, 0, 0));
        pending_tris.push_back(make_tri(0, 0, 1, 0, 0, 0, 0, -1, 0));
        pending_tris.push_back(make_tri(0, 1, 0, 0, 0, 0, 0, 0, -1));
        pending_tris.push_back(make_tri(1, 0, 0, 0, 0, 0, 0, 0, 1));
        pending_tris.push_back(make_tri(0, 0, 1, 0, 0, 0, -1, 0, 0));
        pending_tris.push_back(make_tri(8388607, 8388607, 8388607, -8388608, -8388608,
                                        -8388608, 8388607, -8388608, 8388607));
        pending_tris.push_back(make_tri(-8388608, 0, 0, 8388607, 0, 0, 8388607,
                                        -8388608, 0));
        pending_tris.push_back(make_tri(8388607, -8388608, 8388607, -8388608, 8388607,
                                        -8388608, 8388607, 8388607, -8388608));
        pending_tris.push_back(make_tri(-8388608, -8388608, -8388608, 8388607, 8388607,
                                        8388607, -8388608, 8388607, 8388607));
        pending_tris.push_back(make_tri(-8388608, -8388608, -8388608, -8388608, -8388608,
                                        -8388608, -8388608, -8388608, -8388608));
        pending_tris.push_back(make_tri(1, 1, 0, 0, 0, 0, 0, -1, 0));
        pending_tris.push_back(make_tri(3, 4, 0, 0, 0, 0, 0, 0, 1));
        pending_tris.push_back(make_tri(1, 2, 3, 4, 5, 6, 7, 8, 10));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            mode = $urandom_range(0, 3);
            k = $urandom_range(0, 9);
            if (k == 0)
            begin
                // collinear: a, b, c equally spaced on a line
                ax = rand_coord(1); ay = rand_coord(1); az = rand_coord(1);
                dx = rand_coord(2); dy = rand_coord(2); dz = rand_coord(2);
                pending_tris.push_back(make_tri(ax + dx, ay + dy, az + dz, ax, ay, az,
                                                ax - dx, ay - dy, az - dz));
            end
            else if (k == 1)
            begin
                // triangle in a plane z = const, parallel to the xy plane
                ax = rand_coord(mode);
                pending_tris.push_back(make_tri(rand_coord(mode), rand_coord(mode), ax,
                                                rand_coord(mode), rand_coord(mode), ax,
                                                rand_coord(mode), rand_coord(mode), ax));
            end
            else
                pending_tris.push_back(make_tri(rand_coord(mode), rand_coord(mode),
                                                rand_coord(mode), rand_coord(mode),
                                                rand_coord(mode), rand_coord(mode),
                                                rand_coord(mode), rand_coord(mode),
                                                rand_coord(mode)));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // alternate stretches with random gaps and stalls with full-rate stretches
        while (pending_tris.size() > 0)
        begin
            repeat (200) @(posedge clk);
            no_gap_burst <= ~no_gap_burst;
        end
        wait (!vert_valid);
        wait (expected_normals.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d triangles, %0d degenerate, with random gaps and stalls",
                 tri_count, degen_count);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
